// ----- hdl/dstk_pkg.sv -----
// ----------------------------------------------------------------------------
// dstk_pkg
// Shared types and constants of the data stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dstk_pkg;

  localparam int STACK_DEPTH = 512;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int ERR_W       = 2;
  localparam int DEPTH_OUT_W = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_TWO = DEPTH_W'(2);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_SHL  = 3'd4,
    OP_SHR  = 3'd5,
    OP_DUP  = 3'd6,
    OP_SWAP = 3'd7
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2
  } err_t;

  typedef struct packed {
    logic [DATA_W-1:0]      popped_value;
    err_t                   error;
    logic [DEPTH_OUT_W-1:0] depth_after;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/dstk_if.sv -----
// ----------------------------------------------------------------------------
// dstk_in_if / dstk_out_if
// Valid/ready channels of the data stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface dstk_in_if
  import dstk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface dstk_out_if
  import dstk_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [DATA_W-1:0]      popped_value;
  logic [ERR_W-1:0]       error;
  logic [DEPTH_OUT_W-1:0] depth_after;

  modport source (output valid, output popped_value, output error, output depth_after,
                  input ready);
  modport sink   (input valid, input popped_value, input error, input depth_after,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/dstk_ram.sv -----
// ----------------------------------------------------------------------------
// dstk_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module dstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dstk_seq.sv -----
// ----------------------------------------------------------------------------
// dstk_seq
// Operation sequencer: reads the two top entries, computes, writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module dstk_seq
  import dstk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  dstk_in_if.sink                in_chan,
  // stack memory
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_waddr,
  output logic [DATA_W-1:0]      mem_wdata,
  output logic                   mem_re,
  output logic [ADDR_W-1:0]      mem_raddr_a,
  output logic [ADDR_W-1:0]      mem_raddr_b,
  input  wire logic [DATA_W-1:0] mem_rdata_a,
  input  wire logic [DATA_W-1:0] mem_rdata_b,
  // result to output register
  input  wire logic              res_ready,
  output logic                   res_valid,
  output res_t                   res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SWAP2 = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  op_t                 op_r, op_nxt;
  logic [DATA_W-1:0]   value_r, value_nxt;

  logic                accept;
  logic [DEPTH_W-1:0]  need;
  logic                under;
  logic                over;
  logic [DATA_W-1:0]   top_a;
  logic [DATA_W-1:0]   sec_b;
  logic [DATA_W-1:0]   alu;
  logic                big_shift;

  assign accept    = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  // top entry is a, the one below is b
  assign top_a     = mem_rdata_a;
  assign sec_b     = mem_rdata_b;
  assign big_shift = |top_a[DATA_W-1:5];

  always_comb begin
    case (op_r)
      OP_ADD:  alu = sec_b + top_a;
      OP_SUB:  alu = sec_b - top_a;
      OP_SHL:  alu = big_shift ? '0 : (sec_b << top_a[4:0]);
      OP_SHR:  alu = big_shift ? '0 : (sec_b >> top_a[4:0]);
      default: alu = '0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_PUSH:        need = '0;
      OP_POP, OP_DUP: need = DEPTH_ONE;
      default:        need = DEPTH_TWO;
    endcase
  end

  assign under = (depth_r < need);
  assign over  = ((op_r == OP_PUSH) || (op_r == OP_DUP)) && (depth_r >= DEPTH_MAX);

  // reads of the top pair go out with the accepted beat
  assign mem_re      = accept;
  assign mem_raddr_a = ADDR_W'(depth_r - DEPTH_ONE);
  assign mem_raddr_b = ADDR_W'(depth_r - DEPTH_TWO);

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    op_nxt     = op_r;
    value_nxt  = value_r;
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(depth_r);
    mem_wdata  = value_r;
    res_valid  = 1'b0;
    res.popped_value = '0;
    res.error        = ERR_NONE;
    res.depth_after  = DEPTH_OUT_W'(depth_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = op_t'(in_chan.op);
          value_nxt = in_chan.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (under) begin
            depth_nxt = '0;
            res.error = ERR_UNDER;
          end else if (over) begin
            res.error = ERR_OVER;
          end else begin
            case (op_r)
              OP_PUSH: begin
                mem_we    = 1'b1;
                depth_nxt = depth_r + DEPTH_ONE;
              end
              OP_POP: begin
                res.popped_value = top_a;
                depth_nxt        = depth_r - DEPTH_ONE;
              end
              OP_DUP: begin
                mem_we    = 1'b1;
                mem_wdata = top_a;
                depth_nxt = depth_r + DEPTH_ONE;
              end
              OP_SWAP: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(depth_r - DEPTH_ONE);
                mem_wdata = sec_b;
                state_nxt = S_SWAP2;
              end
              default: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(depth_r - DEPTH_TWO);
                mem_wdata = alu;
                depth_nxt = depth_r - DEPTH_ONE;
              end
            endcase
          end
          res.depth_after = DEPTH_OUT_W'(depth_nxt);
        end
      end

      S_SWAP2: begin
        // read data still holds the old top; it goes one slot down
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(depth_r - DEPTH_TWO);
        mem_wdata = top_a;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/stack_machine_data_stack_unit.sv -----
// ----------------------------------------------------------------------------
// stack_machine_data_stack_unit
// Data stack with push, pop, add, subtract, shifts, dup and swap.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   op[2:0], value[31:0]
//   out_chan  out  valid/ready   popped_value[31:0], error[1:0], depth_after[9:0]
//
// Steps per beat: accept + read, then compute + write back; swap adds a
//   second write, since it needs the single write port a second time.
// Results land in an output register, so the next beat is taken while the
//   last result waits; the compute cycle stalls only if that register is
//   still full and not being drained.
// Reset: synchronous, active low; clears the depth counter, sequencer and
//   output valid. Stack memory contents are not cleared; only written
//   entries ever reach a result.
// Stack memory: STACK_DEPTH x 32, one write and two registered read ports.
//
`default_nettype none

module stack_machine_data_stack_unit
  import dstk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  dstk_in_if.sink   in_chan,
  dstk_out_if.source out_chan
);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr_a;
  logic [ADDR_W-1:0] mem_raddr_b;
  logic [DATA_W-1:0] mem_rdata_a;
  logic [DATA_W-1:0] mem_rdata_b;

  logic res_ready;
  logic res_valid;
  res_t res;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  dstk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  dstk_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register: free when empty or draining this cycle
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = out_res_r.popped_value;
  assign out_chan.error        = out_res_r.error;
  assign out_chan.depth_after  = out_res_r.depth_after;

endmodule

`default_nettype wire

// ----- hdl/dstk_chk.sv -----
// ----------------------------------------------------------------------------
// dstk_chk
// Port-level checks of the data stack unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dstk_chk
  import dstk_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [DATA_W-1:0]      out_popped_value,
  input wire logic [ERR_W-1:0]       out_error,
  input wire logic [DEPTH_OUT_W-1:0] out_depth_after
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value)
      && $stable(out_error) && $stable(out_depth_after))
    else $error("result beat changed under stall");

  // underflow always empties the stack
  a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error == ERR_UNDER) |-> (out_depth_after == '0))
    else $error("underflow with nonzero depth");

  // only a clean operation returns a nonzero word
  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_popped_value != '0) |-> (out_error == ERR_NONE))
    else $error("popped value on error");

  // one beat in the sequencer: accept closes the input until that beat is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stack_machine_data_stack_unit dstk_chk u_dstk_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_popped_value (out_chan.popped_value),
  .out_error        (out_chan.error),
  .out_depth_after  (out_chan.depth_after)
);

`default_nettype wire

// ----- tb/tb_stack_machine_data_stack_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_machine_data_stack_unit
// Self-checking bench for the data stack unit. Stack words are driven in
// beats on the input channel. A shadow copy of the stack predicts popped
// value, error code and depth for every accepted beat. Each result beat is
// checked against the oldest prediction. Directed runs cover empty-stack
// underflow, word arithmetic and full-stack overflow, followed by a long
// random mix with random stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_stack_machine_data_stack_unit;
  import dstk_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  dstk_in_if  in_chan();
  dstk_out_if out_chan();

  stack_machine_data_stack_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow stack: same contents and depth the unit should hold.
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int                shadow_depth = 0;

  // Predicted result beats, oldest first.
  res_t dstk_results_due [$];

  // Stall controls: upper bound of the per-beat random wait on each side,
  // plus a one-shot long hold of out ready (counted by the result process).
  int in_gap_max      = 0;
  int out_gap_max     = 0;
  int out_hold_cycles = 0;
  int err_count       = 0;

  // --------------------------------------------------------------------------
  // Prediction: apply one stack op to the shadow state, return the result.
  // --------------------------------------------------------------------------
  function automatic res_t calc_stack_op(input op_t op, input logic [DATA_W-1:0] val);
    res_t              r;
    int                need;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    r.popped_value = '0;
    r.error        = ERR_NONE;
    if (op == OP_POP || op == OP_DUP) need = 1;
    else if (op == OP_PUSH)           need = 0;
    else                              need = 2;

    // Underflow wins over overflow (dup on empty), and empties the stack.
    if (shadow_depth < need) begin
      r.error      = ERR_UNDER;
      shadow_depth = 0;
    end else if ((op == OP_PUSH || op == OP_DUP) && shadow_depth >= STACK_DEPTH) begin
      r.error = ERR_OVER;  // full: state left alone
    end else begin
      case (op)
        OP_PUSH: begin
          shadow_stack[shadow_depth] = val;
          shadow_depth++;
        end
        OP_POP: begin
          shadow_depth--;
          r.popped_value = shadow_stack[shadow_depth];
        end
        OP_DUP: begin
          shadow_stack[shadow_depth] = shadow_stack[shadow_depth-1];
          shadow_depth++;
        end
        OP_SWAP: begin
          a = shadow_stack[shadow_depth-1];
          shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
          shadow_stack[shadow_depth-2] = a;
        end
        default: begin
          // a = top, b = next; result b op a replaces both
          a = shadow_stack[shadow_depth-1];
          b = shadow_stack[shadow_depth-2];
          case (op)
            OP_ADD:  b = b + a;
            OP_SUB:  b = b - a;
            OP_SHL:  b = (a >= 32) ? '0 : (b << a[4:0]);
            default: b = (a >= 32) ? '0 : (b >> a[4:0]);
          endcase
          shadow_stack[shadow_depth-2] = b;
          shadow_depth--;
        end
      endcase
    end
    r.depth_after = DEPTH_OUT_W'(shadow_depth);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random content helpers
  // --------------------------------------------------------------------------
  // Words with a fair share of small shift counts and all-zero/all-one.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1:    return DATA_W'($urandom_range(0, 40));
      2:       return $urandom_range(0, 1) ? {DATA_W{1'b1}} : '0;
      default: return $urandom;
    endcase
  endfunction

  // Op choice leans on push when shallow and away from it when deep, so the
  // depth wanders instead of sticking at empty. A few ops are plain noise.
  function automatic op_t pick_stack_op();
    int push_pct;
    if ($urandom_range(0, 19) == 0) return op_t'($urandom_range(0, 7));
    if (shadow_depth < 3)        push_pct = 60;
    else if (shadow_depth > 400) push_pct = 15;
    else                         push_pct = 35;
    if ($urandom_range(1, 100) <= push_pct) return OP_PUSH;
    return op_t'($urandom_range(1, 7));
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one beat per call. Valid stays high into the next call when
  // its gap is zero, so it is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input op_t op, input logic [DATA_W-1:0] val);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.value <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    dstk_results_due.push_back(calc_stack_op(op, val));
  endtask

  // Sender goes quiet until every predicted beat has come back.
  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    while (dstk_results_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: compare an accepted result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_result();
    res_t exp;
    if (dstk_results_due.size() == 0) begin
      err_count++;
      $display("%0t: result beat with none due: pop %h err %0d depth %0d", $time,
               out_chan.popped_value, out_chan.error, out_chan.depth_after);
    end else begin
      exp = dstk_results_due.pop_front();
      if (out_chan.popped_value !== exp.popped_value) begin
        err_count++;
        $display("%0t: popped_value exp %h act %h", $time,
                 exp.popped_value, out_chan.popped_value);
      end
      if (out_chan.error !== exp.error) begin
        err_count++;
        $display("%0t: error exp %0d act %0d", $time, exp.error, out_chan.error);
      end
      if (out_chan.depth_after !== exp.depth_after) begin
        err_count++;
        $display("%0t: depth_after exp %0d act %0d", $time,
                 exp.depth_after, out_chan.depth_after);
      end
    end
  endtask

  // Result sink: random stall per beat, or the long hold when one is asked.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (out_hold_cycles) @(posedge clk);
        out_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, out_gap_max);
        if (stall > 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every consuming op on an empty stack, then two-operand ops with one entry.
  task automatic test_empty_underflow();
    op_t empty_ops [7] = '{OP_POP, OP_DUP, OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_SWAP};
    in_gap_max  = 3;
    out_gap_max = 3;
    foreach (empty_ops[i]) send_beat(empty_ops[i], rand_word());
    send_beat(OP_PUSH, 32'h0000_0005);
    send_beat(OP_ADD,  '0);
    send_beat(OP_PUSH, 32'h1234_5678);
    send_beat(OP_SWAP, '0);
  endtask

  // Wraparound add/sub, shifts at the edge of the word and past it,
  // then swap/dup/pop order.
  task automatic test_word_ops();
    send_beat(OP_PUSH, 32'hFFFF_FFFF);
    send_beat(OP_PUSH, 32'h0000_0001);
    send_beat(OP_ADD,  '0);            // wraps to 0
    send_beat(OP_PUSH, 32'h0000_0001);
    send_beat(OP_SUB,  '0);            // 0 - 1
    send_beat(OP_PUSH, 32'd31);
    send_beat(OP_SHL,  '0);            // top bit only
    send_beat(OP_PUSH, 32'd31);
    send_beat(OP_SHR,  '0);            // back to 1
    send_beat(OP_PUSH, 32'hFFFF_FFFF);
    send_beat(OP_SHL,  '0);            // huge count -> 0
    send_beat(OP_PUSH, 32'hA5A5_A5A5);
    send_beat(OP_SWAP, '0);
    send_beat(OP_DUP,  '0);
    send_beat(OP_POP,  '0);
    send_beat(OP_POP,  '0);
    send_beat(OP_POP,  '0);
    wait_drain();
  endtask

  // Fill to the top, hit overflow on push and dup, churn near full, back off.
  task automatic test_fill_overflow();
    in_gap_max  = 0;
    out_gap_max = 0;
    while (shadow_depth < STACK_DEPTH) send_beat(OP_PUSH, rand_word());
    send_beat(OP_PUSH, rand_word());
    send_beat(OP_DUP,  '0);
    in_gap_max  = 4;
    out_gap_max = 4;
    repeat (30) send_beat(pick_stack_op(), rand_word());
    in_gap_max  = 1;
    out_gap_max = 1;
    repeat (200) send_beat(OP_POP, rand_word());
    wait_drain();
  endtask

  // Long out hold while the input keeps pushing beats back to back, so the
  // unit fills and drops in ready; then the sender waits for all results.
  task automatic test_output_holdoff();
    in_gap_max      = 0;
    out_gap_max     = 0;
    out_hold_cycles = 300;
    repeat (40) send_beat(pick_stack_op(), rand_word());
    wait_drain();
  endtask

  // Random mix; stall bounds are redrawn per stretch, including no stalls.
  task automatic test_random_mix(input int n_beats);
    int bounds [3] = '{0, 3, 12};
    for (int i = 0; i < n_beats; i++) begin
      if (i % 75 == 0) begin
        in_gap_max  = bounds[$urandom_range(0, 2)];
        out_gap_max = bounds[$urandom_range(0, 2)];
      end
      send_beat(pick_stack_op(), rand_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.op     <= OP_PUSH;
    in_chan.value  <= '0;
    out_chan.ready <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_underflow();
    test_word_ops();
    test_fill_overflow();
    test_random_mix(400);
    test_output_holdoff();
    test_random_mix(450);

    wait_drain();
    repeat (16) @(posedge clk);  // catch any stray result beat
    if (err_count == 0) $display("PASS");
    else                $display("FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
